FILE: rtl/rotary_encoder_with_button_top_macros.svh
// assertion helpers for the checker file
// each macro expects i_clk and i_rst_n in scope
`ifndef ROTARY_ENCODER_WITH_BUTTON_TOP_MACROS_SVH
`define ROTARY_ENCODER_WITH_BUTTON_TOP_MACROS_SVH

// same-cycle implication
`define REB_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define REB_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/reb_pkg.sv
package reb_pkg;

    localparam int TRANSITIONS_PER_DETENT_DEF = 4;
    localparam int TICK_W      = 32;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    // input item
    typedef struct packed {
        logic       pin_a;
        logic       pin_b;
        logic       button_level;
        logic [1:0] queue_slots;
    } t_in_item;

    // result item
    typedef struct packed {
        logic              rotation_valid;
        logic signed [7:0] rotation_delta;
        logic              button_valid;
        logic [1:0]        button_command;
    } t_out_item;

    // configuration registers
    typedef struct packed {
        logic [6:0]  volume_step;
        logic        reverse_direction;
        logic [1:0]  rest_code;
        logic [7:0]  debounce_ticks;
        logic [15:0] long_press_ticks;
        logic [15:0] double_click_ticks;
        logic [6:0]  delta_limit;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        volume_step:        7'd1,
        reverse_direction:  1'b0,
        rest_code:          2'd3,
        debounce_ticks:     8'd30,
        long_press_ticks:   16'd800,
        double_click_ticks: 16'd400,
        delta_limit:        7'd100
    };

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_VOLUME_STEP       = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_REVERSE_DIRECTION = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_REST_CODE         = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_DEBOUNCE_TICKS    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_LONG_PRESS_TICKS  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_DOUBLE_CLICK_TICKS = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_DELTA_LIMIT       = 3'd6;

    // button commands
    localparam logic [1:0] CMD_SINGLE = 2'd0;
    localparam logic [1:0] CMD_DOUBLE = 2'd1;
    localparam logic [1:0] CMD_LONG   = 2'd2;

    // detent rest positions
    localparam logic [1:0] REST_AB_LOW  = 2'b00;
    localparam logic [1:0] REST_AB_HIGH = 2'b11;

    // gray-code step: +1, -1, or 0 for no move or a skipped code
    function automatic logic signed [1:0] gray_move(input logic [1:0] prev_ab,
                                                    input logic [1:0] cur_ab);
        logic signed [1:0] step;
        case ({prev_ab, cur_ab}) inside
            4'd1, 4'd7, 4'd8, 4'd14:  step = -2'sd1;
            4'd2, 4'd4, 4'd11, 4'd13: step = 2'sd1;
            default:                  step = 2'sd0;
        endcase
        return step;
    endfunction

endpackage

FILE: rtl/reb_cfg.sv
module reb_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [reb_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [reb_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output reb_pkg::t_cfg                  o_cfg
);
    import reb_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_VOLUME_STEP:        n_cfg.volume_step        = i_cfg_data[6:0];
                CFG_REVERSE_DIRECTION:  n_cfg.reverse_direction  = i_cfg_data[0];
                CFG_REST_CODE:          n_cfg.rest_code          = i_cfg_data[1:0];
                CFG_DEBOUNCE_TICKS:     n_cfg.debounce_ticks     = i_cfg_data[7:0];
                CFG_LONG_PRESS_TICKS:   n_cfg.long_press_ticks   = i_cfg_data[15:0];
                CFG_DOUBLE_CLICK_TICKS: n_cfg.double_click_ticks = i_cfg_data[15:0];
                CFG_DELTA_LIMIT:        n_cfg.delta_limit        = i_cfg_data[6:0];
                default:                n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

FILE: rtl/reb_quad.sv
module reb_quad #(
    parameter int TRANSITIONS_PER_DETENT = reb_pkg::TRANSITIONS_PER_DETENT_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  logic              i_pin_a,
    input  logic              i_pin_b,
    input  logic [1:0]        i_slots,
    input  reb_pkg::t_cfg     i_cfg,
    output logic              o_rot_valid,
    output logic signed [7:0] o_rot_delta
);
    import reb_pkg::*;

    localparam int CNT_W = $clog2(TRANSITIONS_PER_DETENT + 1) + 1;
    localparam int SUM_W = CNT_W + 1;
    localparam logic signed [SUM_W-1:0] DET_POS = SUM_W'(TRANSITIONS_PER_DETENT);
    localparam logic signed [SUM_W-1:0] DET_NEG = -DET_POS;

    logic [1:0]              r_prev_ab;
    logic [1:0]              n_prev_ab;
    logic signed [CNT_W-1:0] r_count;
    logic signed [CNT_W-1:0] n_count;
    logic signed [7:0]       r_pending;
    logic signed [7:0]       n_pending;

    logic [1:0]              cur_ab;
    logic [1:0]              detent_ab;
    logic signed [1:0]       move;
    logic signed [SUM_W-1:0] cnt_sum;
    logic signed [SUM_W-1:0] cnt_mid;
    logic signed [9:0]       step_ext;
    logic signed [9:0]       lim_ext;
    logic signed [9:0]       addend;
    logic signed [9:0]       acc;
    logic signed [7:0]       acc_sat;
    logic                    go_neg;

    assign cur_ab    = {i_pin_a, i_pin_b};
    assign detent_ab = (i_cfg.rest_code == REST_AB_LOW) ? REST_AB_LOW : REST_AB_HIGH;
    assign move      = gray_move(r_prev_ab, cur_ab);
    assign cnt_sum   = SUM_W'(r_count) + SUM_W'(move);
    assign step_ext  = $signed({3'b000, i_cfg.volume_step});
    assign lim_ext   = $signed({3'b000, i_cfg.delta_limit});

    always_comb begin
        n_prev_ab   = r_prev_ab;
        n_pending   = r_pending;
        cnt_mid     = SUM_W'(r_count);
        go_neg      = 1'b0;
        addend      = '0;
        acc         = '0;
        acc_sat     = '0;
        o_rot_valid = 1'b0;
        o_rot_delta = '0;

        if (cur_ab != r_prev_ab) begin
            n_prev_ab = cur_ab;
            // skipped code or overrun restarts the count
            if (move == 2'sd0) begin
                cnt_mid = '0;
            end else if (cnt_sum > DET_POS || cnt_sum < DET_NEG) begin
                cnt_mid = '0;
            end else begin
                cnt_mid = cnt_sum;
            end
            if (cur_ab == detent_ab) begin
                if (cnt_mid == DET_POS || cnt_mid == DET_NEG) begin
                    go_neg = (cnt_mid > 0) ^ i_cfg.reverse_direction;
                    addend = go_neg ? -step_ext : step_ext;
                    acc    = 10'(r_pending) + addend;
                    if (acc > lim_ext) begin
                        acc_sat = 8'(lim_ext);
                    end else if (acc < -lim_ext) begin
                        acc_sat = 8'(-lim_ext);
                    end else begin
                        acc_sat = 8'(acc);
                    end
                    n_pending = acc_sat;
                end
                cnt_mid = '0;
            end
        end

        // rotation takes the first free slot
        if (n_pending != 8'sd0 && i_slots != 2'd0) begin
            o_rot_valid = 1'b1;
            o_rot_delta = n_pending;
            n_pending   = '0;
        end
    end

    assign n_count = CNT_W'(cnt_mid);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_ab <= REST_AB_HIGH;
            r_count   <= '0;
            r_pending <= '0;
        end else if (i_fire) begin
            r_prev_ab <= n_prev_ab;
            r_count   <= n_count;
            r_pending <= n_pending;
        end
    end

endmodule

FILE: rtl/reb_button.sv
module reb_button (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_fire,
    input  logic          i_button_level,
    input  logic          i_slot_free,
    input  reb_pkg::t_cfg i_cfg,
    output logic          o_btn_valid,
    output logic [1:0]    o_btn_cmd
);
    import reb_pkg::*;

    logic [TICK_W-1:0] r_tick;
    logic [TICK_W-1:0] n_tick;
    logic              r_last_raw;
    logic              n_last_raw;
    logic              r_stable;
    logic              n_stable;
    logic [TICK_W-1:0] r_raw_at;
    logic [TICK_W-1:0] n_raw_at;
    logic [TICK_W-1:0] r_press_at;
    logic [TICK_W-1:0] n_press_at;
    logic              r_long_sent;
    logic              n_long_sent;
    logic              r_click_pend;
    logic              n_click_pend;
    logic [TICK_W-1:0] r_click_at;
    logic [TICK_W-1:0] n_click_at;

    logic              raw_chg;
    logic [TICK_W-1:0] since_raw;
    logic              deb_ok;
    logic [TICK_W-1:0] held_len;
    logic [TICK_W-1:0] since_click_old;
    logic [TICK_W-1:0] since_press_old;
    logic [TICK_W-1:0] since_press;
    logic [TICK_W-1:0] since_click;
    logic [TICK_W-1:0] deb_lim;
    logic [TICK_W-1:0] long_lim;
    logic [TICK_W-1:0] dbl_lim;
    logic              press_now;
    logic              click_new;

    assign deb_lim  = TICK_W'(i_cfg.debounce_ticks);
    assign long_lim = TICK_W'(i_cfg.long_press_ticks);
    assign dbl_lim  = TICK_W'(i_cfg.double_click_ticks);

    assign raw_chg         = i_button_level != r_last_raw;
    assign n_last_raw      = i_button_level;
    assign n_raw_at        = raw_chg ? r_tick : r_raw_at;
    assign since_raw       = raw_chg ? '0 : (r_tick - r_raw_at);
    assign deb_ok          = (since_raw >= deb_lim) && (i_button_level != r_stable);
    assign held_len        = n_raw_at - r_press_at;
    assign since_click_old = r_tick - r_click_at;
    assign since_press_old = r_tick - r_press_at;
    assign n_tick          = r_tick + TICK_W'(1);

    always_comb begin
        n_stable     = r_stable;
        n_press_at   = r_press_at;
        n_long_sent  = r_long_sent;
        n_click_pend = r_click_pend;
        n_click_at   = r_click_at;
        press_now    = 1'b0;
        click_new    = 1'b0;
        o_btn_valid  = 1'b0;
        o_btn_cmd    = CMD_SINGLE;

        // debounced edge
        if (deb_ok) begin
            n_stable = i_button_level;
            if (!i_button_level) begin
                n_press_at  = r_tick;
                n_long_sent = 1'b0;
                press_now   = 1'b1;
            end else if (!r_long_sent) begin
                if (held_len >= long_lim) begin
                    // long press at release, dropped if the queue is full
                    n_click_pend = 1'b0;
                    if (i_slot_free) begin
                        o_btn_valid = 1'b1;
                        o_btn_cmd   = CMD_LONG;
                    end
                end else if (r_click_pend && since_click_old <= dbl_lim) begin
                    if (i_slot_free) begin
                        o_btn_valid  = 1'b1;
                        o_btn_cmd    = CMD_DOUBLE;
                        n_click_pend = 1'b0;
                    end
                end else begin
                    n_click_pend = 1'b1;
                    n_click_at   = r_tick;
                    click_new    = 1'b1;
                end
            end
        end

        since_press = press_now ? '0 : since_press_old;
        since_click = click_new ? '0 : since_click_old;

        // long press while still held, retried until it goes out
        if (!n_stable && !n_long_sent && since_press >= long_lim) begin
            n_click_pend = 1'b0;
            n_long_sent  = i_slot_free;
            if (i_slot_free) begin
                o_btn_valid = 1'b1;
                o_btn_cmd   = CMD_LONG;
            end
        end

        // double-click window expired
        if (n_stable && n_click_pend && since_click > dbl_lim) begin
            if (i_slot_free) begin
                o_btn_valid  = 1'b1;
                o_btn_cmd    = CMD_SINGLE;
                n_click_pend = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick       <= '0;
            r_last_raw   <= 1'b1;
            r_stable     <= 1'b1;
            r_raw_at     <= '0;
            r_press_at   <= '0;
            r_long_sent  <= 1'b0;
            r_click_pend <= 1'b0;
            r_click_at   <= '0;
        end else if (i_fire) begin
            r_tick       <= n_tick;
            r_last_raw   <= n_last_raw;
            r_stable     <= n_stable;
            r_raw_at     <= n_raw_at;
            r_press_at   <= n_press_at;
            r_long_sent  <= n_long_sent;
            r_click_pend <= n_click_pend;
            r_click_at   <= n_click_at;
        end
    end

endmodule

FILE: rtl/rotary_encoder_with_button_top.sv
// channel   direction  handshake              payload
// in        into       i_in_valid/o_in_stall  i_in_item (pins, button, queue slots)
// out       out of     o_out_valid/i_out_stall o_out_item (rotation, button command)
// cfg       into       i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
//
// one item per cycle while the output is not stalled; an item waits in the input register,
// is decoded there and lands in the result register
// reset (i_rst_n low at a clock edge) restores valid flags, configuration and decoder state
// a stalled result holds the result register; the input register still takes
// an item while it is empty or the result register is free or being taken this cycle
module rotary_encoder_with_button_top #(
    parameter int TRANSITIONS_PER_DETENT = reb_pkg::TRANSITIONS_PER_DETENT_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // item input
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  reb_pkg::t_in_item               i_in_item,
    // result output
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output reb_pkg::t_out_item              o_out_item,
    // register writes
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [reb_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [reb_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import reb_pkg::*;

    // pipeline registers
    logic      r_in_valid;
    logic      n_in_valid;
    t_in_item  r_in_item;
    logic      r_out_valid;
    logic      n_out_valid;
    t_out_item r_out_item;
    t_out_item n_out_item;

    logic             advance;   // result register free or emptying this cycle
    logic             fire;      // the held item is decoded and committed
    t_cfg             cfg;
    logic             rot_valid;
    logic signed [7:0] rot_delta;
    logic [1:0]       slots_after;
    logic             slot_free;
    logic             btn_valid;
    logic [1:0]       btn_cmd;

    assign advance    = !r_out_valid || !i_out_stall;
    assign fire       = r_in_valid && advance;
    assign o_in_stall = r_in_valid && !advance;

    // configuration registers
    reb_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // quadrature decode and delta accumulation, first claim on a slot
    reb_quad #(
        .TRANSITIONS_PER_DETENT (TRANSITIONS_PER_DETENT)
    ) u_quad (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_pin_a     (r_in_item.pin_a),
        .i_pin_b     (r_in_item.pin_b),
        .i_slots     (r_in_item.queue_slots),
        .i_cfg       (cfg),
        .o_rot_valid (rot_valid),
        .o_rot_delta (rot_delta)
    );

    // slots left for the button after a rotation push
    assign slots_after = r_in_item.queue_slots - {1'b0, rot_valid};
    assign slot_free   = slots_after != 2'd0;

    // debounce and press classification
    reb_button u_button (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_fire         (fire),
        .i_button_level (r_in_item.button_level),
        .i_slot_free    (slot_free),
        .i_cfg          (cfg),
        .o_btn_valid    (btn_valid),
        .o_btn_cmd      (btn_cmd)
    );

    always_comb begin
        n_in_valid  = o_in_stall ? r_in_valid : i_in_valid;
        n_out_valid = advance ? r_in_valid : r_out_valid;
        n_out_item.rotation_valid = rot_valid;
        n_out_item.rotation_delta = rot_delta;
        n_out_item.button_valid   = btn_valid;
        n_out_item.button_command = btn_cmd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_item <= i_in_item;
        end
        if (fire) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

FILE: rtl/reb_checker.sv
`include "rotary_encoder_with_button_top_macros.svh"

module reb_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input reb_pkg::t_out_item o_out_item
);
    import reb_pkg::*;

    logic rot_ok;
    logic btn_ok;

    // rotation pushes carry a nonzero in-range amount, idle rotation reads zero
    assign rot_ok = o_out_item.rotation_valid ?
                    (o_out_item.rotation_delta != 8'sd0 &&
                     o_out_item.rotation_delta != -8'sd128) :
                    (o_out_item.rotation_delta == 8'sd0);

    // button command is a known code and zero when nothing was pushed
    assign btn_ok = (o_out_item.button_valid || o_out_item.button_command == CMD_SINGLE) &&
                    (o_out_item.button_command == CMD_SINGLE ||
                     o_out_item.button_command == CMD_DOUBLE ||
                     o_out_item.button_command == CMD_LONG);

    // a stalled result stays put
    `REB_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_item), "result changed while stalled")

    // input only backs up when the result side is blocked
    `REB_ASSERT_NOW(a_in_stall_cause, o_in_stall, o_out_valid && i_out_stall, "input stalled")

    `REB_ASSERT_NOW(a_rot_delta, o_out_valid, rot_ok, "bad rotation delta")

    `REB_ASSERT_NOW(a_btn_cmd, o_out_valid, btn_ok, "bad button command")

endmodule

bind rotary_encoder_with_button_top reb_checker u_reb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);

FILE: sim/rotary_encoder_with_button_top_test.sv
`timescale 1ns / 1ps

module rotary_encoder_with_button_top_test;
    import reb_pkg::*;

    localparam int DETENT_STEPS = TRANSITIONS_PER_DETENT_DEF;
    localparam int IDLE_PCT     = 23;
    // cycles in which neither side takes a break
    localparam int CALM_FROM    = 600;
    localparam int CALM_TO      = 1100;
    // longest button level the stimulus holds, keeps slow settings short
    localparam int HOLD_CAP     = 300;

    // rotation stimulus modes
    localparam int ROT_TURN  = 0;
    localparam int ROT_HOLD  = 1;
    localparam int ROT_NOISE = 2;
    localparam int ROT_SKIP  = 3;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_in_valid = 1'b0;
    logic                   o_in_stall;
    t_in_item               i_in_item = '0;
    logic                   o_out_valid;
    logic                   i_out_stall = 1'b0;
    t_out_item              o_out_item;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_INDEX_W-1:0] i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;

    rotary_encoder_with_button_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    int unsigned cycle_num = 0;
    always @(posedge i_clk) begin
        cycle_num <= cycle_num + 1;
    end

    // ticks waiting to be driven, and the commands they should produce
    t_in_item  pending_ticks[$];
    t_out_item expected_cmds[$];
    t_out_item head_cmd;
    int        mismatch_count = 0;
    int        result_num = 0;

    // ------------------------------------------------------------------
    // encoder and button predictor, its own copy of registers and state
    // ------------------------------------------------------------------
    t_cfg        model_cfg;
    logic [31:0] tick_stamp;
    logic [1:0]  seen_ab;
    int          step_count;      // signed gray steps since the last rest
    int          held_delta;      // rotation waiting for a free queue slot
    logic        raw_btn;
    logic        stable_btn;
    logic [31:0] raw_edge_at;
    logic [31:0] press_at;
    logic [31:0] click_at;
    logic        long_sent;
    logic        click_waiting;
    int          slots_free;
    t_out_item   predicted;

    task automatic reset_model();
        model_cfg     = CFG_RESET;
        tick_stamp    = '0;
        seen_ab       = REST_AB_HIGH;
        step_count    = 0;
        held_delta    = 0;
        raw_btn       = 1'b1;
        stable_btn    = 1'b1;
        raw_edge_at   = '0;
        press_at      = '0;
        long_sent     = 1'b0;
        click_waiting = 1'b0;
        click_at      = '0;
    endtask

    task automatic apply_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_VOLUME_STEP:        model_cfg.volume_step = data[6:0];
            CFG_REVERSE_DIRECTION:  model_cfg.reverse_direction = data[0];
            CFG_REST_CODE:          model_cfg.rest_code = data[1:0];
            CFG_DEBOUNCE_TICKS:     model_cfg.debounce_ticks = data[7:0];
            CFG_LONG_PRESS_TICKS:   model_cfg.long_press_ticks = data;
            CFG_DOUBLE_CLICK_TICKS: model_cfg.double_click_ticks = data;
            CFG_DELTA_LIMIT:        model_cfg.delta_limit = data[6:0];
            default: ;
        endcase
    endtask

    // position around the quadrature cycle 00, 01, 11, 10
    function automatic logic [1:0] ab_to_pos(input logic [1:0] ab);
        logic [1:0] pos;
        case (ab)
            2'b00:   pos = 2'd0;
            2'b01:   pos = 2'd1;
            2'b11:   pos = 2'd2;
            default: pos = 2'd3;
        endcase
        return pos;
    endfunction

    function automatic logic [1:0] pos_to_ab(input logic [1:0] pos);
        logic [1:0] ab;
        case (pos)
            2'd0:    ab = 2'b00;
            2'd1:    ab = 2'b01;
            2'd2:    ab = 2'b11;
            default: ab = 2'b10;
        endcase
        return ab;
    endfunction

    // forward around the cycle counts down, backward counts up, a skip is no move
    function automatic int quad_move(input logic [1:0] from_ab, input logic [1:0] to_ab);
        logic [1:0] diff;
        diff = ab_to_pos(to_ab) - ab_to_pos(from_ab);
        if (diff == 2'd1) return -1;
        if (diff == 2'd3) return 1;
        return 0;
    endfunction

    // takes a queue slot for a button command if one is left
    function automatic logic try_push(input logic [1:0] cmd);
        if (slots_free == 0) return 1'b0;
        slots_free--;
        predicted.button_valid   = 1'b1;
        predicted.button_command = cmd;
        return 1'b1;
    endfunction

    function automatic t_out_item predict_tick(input t_in_item it);
        logic [31:0] now;
        logic [1:0]  cur_ab;
        logic [1:0]  rest_ab;
        int          mv;
        int          dir;
        int          lim;
        int          sum;
        now       = tick_stamp;
        cur_ab    = {it.pin_a, it.pin_b};
        rest_ab   = (model_cfg.rest_code == REST_AB_LOW) ? REST_AB_LOW : REST_AB_HIGH;
        slots_free = int'(it.queue_slots);
        predicted = '0;

        // quadrature decode
        if (cur_ab != seen_ab) begin
            mv = quad_move(seen_ab, cur_ab);
            seen_ab = cur_ab;
            if (mv == 0) begin
                step_count = 0;
            end else begin
                step_count += mv;
                if (step_count > DETENT_STEPS || step_count < -DETENT_STEPS)
                    step_count = 0;
            end
            if (cur_ab == rest_ab) begin
                if (step_count == DETENT_STEPS || step_count == -DETENT_STEPS) begin
                    dir = (step_count > 0) ? -1 : 1;
                    if (model_cfg.reverse_direction) dir = -dir;
                    lim = int'(model_cfg.delta_limit);
                    sum = held_delta + dir * int'(model_cfg.volume_step);
                    if (sum > lim) sum = lim;
                    if (sum < -lim) sum = -lim;
                    held_delta = sum;
                end
                step_count = 0;
            end
        end

        // rotation goes to the queue first
        if (held_delta != 0 && slots_free > 0) begin
            slots_free--;
            predicted.rotation_valid = 1'b1;
            predicted.rotation_delta = held_delta[7:0];
            held_delta = 0;
        end

        // button debounce, all tick differences wrap at 32 bits
        if (it.button_level != raw_btn) begin
            raw_btn = it.button_level;
            raw_edge_at = now;
        end
        if ((now - raw_edge_at) >= model_cfg.debounce_ticks && it.button_level != stable_btn) begin
            stable_btn = it.button_level;
            if (!it.button_level) begin
                press_at = now;
                long_sent = 1'b0;
            end else if (!long_sent) begin
                if ((raw_edge_at - press_at) >= model_cfg.long_press_ticks) begin
                    click_waiting = 1'b0;
                    void'(try_push(CMD_LONG));
                end else if (click_waiting &&
                             (now - click_at) <= model_cfg.double_click_ticks) begin
                    if (try_push(CMD_DOUBLE)) click_waiting = 1'b0;
                end else begin
                    click_waiting = 1'b1;
                    click_at = now;
                end
            end
        end
        if (!stable_btn && !long_sent && (now - press_at) >= model_cfg.long_press_ticks) begin
            click_waiting = 1'b0;
            long_sent = try_push(CMD_LONG);
        end
        if (stable_btn && click_waiting && (now - click_at) > model_cfg.double_click_ticks) begin
            if (try_push(CMD_SINGLE)) click_waiting = 1'b0;
        end

        tick_stamp = now + 1;
        return predicted;
    endfunction

    // ------------------------------------------------------------------
    // stimulus generator: encoder turns, button presses, queue pressure
    // ------------------------------------------------------------------
    logic [1:0] gen_pos = 2'd2;
    logic [1:0] gen_rest_pos = 2'd2;
    logic       gen_btn = 1'b1;
    logic       rot_home = 1'b0;
    int         rot_mode = ROT_HOLD;
    int         rot_dir = 1;
    int         rot_left = 0;
    int         rot_back = 0;
    int         btn_left = 0;
    int         full_left = 0;

    function automatic t_in_item gen_tick();
        t_in_item it;
        int       deb;
        int       lng;
        int       dbl;
        int       r;
        it  = '0;
        deb = int'(model_cfg.debounce_ticks);
        lng = int'(model_cfg.long_press_ticks);
        dbl = int'(model_cfg.double_click_ticks);

        // pick the next rotation gesture
        if (rot_left == 0) begin
            if (rot_back > 0) begin
                // unwind a partial turn back to where it started
                rot_dir  = -rot_dir;
                rot_left = rot_back;
                rot_back = 0;
                rot_mode = ROT_TURN;
            end else if (rot_home) begin
                gen_pos  = gen_rest_pos;
                rot_home = 1'b0;
                rot_mode = ROT_HOLD;
                rot_left = 1;
            end else begin
                r = $urandom_range(0, 99);
                rot_dir = ($urandom_range(0, 1) != 0) ? 1 : -1;
                if (r < 45) begin
                    rot_mode = ROT_TURN;
                    rot_left = DETENT_STEPS * $urandom_range(1, 3);
                end else if (r < 65) begin
                    rot_mode = ROT_HOLD;
                    rot_left = $urandom_range(1, 8);
                end else if (r < 78) begin
                    rot_mode = ROT_TURN;
                    rot_left = $urandom_range(1, DETENT_STEPS - 1);
                    rot_back = rot_left;
                end else if (r < 90) begin
                    rot_mode = ROT_NOISE;
                    rot_left = $urandom_range(1, 4);
                    rot_home = 1'b1;
                end else begin
                    rot_mode = ROT_SKIP;
                    rot_left = 1;
                    rot_home = 1'b1;
                end
            end
        end
        case (rot_mode)
            ROT_TURN: begin
                // a turn lingers on some codes
                if ($urandom_range(0, 3) != 0) begin
                    gen_pos = gen_pos + 2'(rot_dir);
                    rot_left--;
                end
            end
            ROT_NOISE: begin
                gen_pos = 2'($urandom_range(0, 3));
                rot_left--;
            end
            ROT_SKIP: begin
                gen_pos = gen_pos + 2'd2;
                rot_left--;
            end
            default: rot_left--;
        endcase

        // button: bounces, clicks, pairs of clicks and long holds
        if (btn_left == 0) begin
            gen_btn = !gen_btn;
            r = $urandom_range(0, 99);
            if (r < 20) begin
                btn_left = $urandom_range(1, deb);
            end else if (!gen_btn) begin
                if (r < 65) btn_left = $urandom_range(deb + 1, deb + lng);
                else btn_left = deb + lng + $urandom_range(0, 8);
            end else begin
                if (r < 60) btn_left = $urandom_range(deb + 1, deb + dbl);
                else btn_left = deb + dbl + $urandom_range(1, 40);
            end
            if (btn_left > HOLD_CAP) btn_left = $urandom_range(HOLD_CAP - 50, HOLD_CAP);
        end
        btn_left--;

        // queue slots, with bursts of a full queue
        if (full_left > 0) begin
            it.queue_slots = 2'd0;
            full_left--;
        end else if ($urandom_range(0, 99) < 4) begin
            full_left = $urandom_range(3, 40);
            it.queue_slots = 2'd0;
        end else if ($urandom_range(0, 99) < 10) begin
            it.queue_slots = 2'd0;
        end else begin
            it.queue_slots = 2'($urandom_range(1, 3));
        end

        {it.pin_a, it.pin_b} = pos_to_ab(gen_pos);
        it.button_level = gen_btn;
        return it;
    endfunction

    // directed tick, keeps the generator in step with the pins
    task automatic queue_tick(input logic [1:0] ab, input logic btn, input logic [1:0] slots);
        t_in_item it;
        it.pin_a        = ab[1];
        it.pin_b        = ab[0];
        it.button_level = btn;
        it.queue_slots  = slots;
        gen_pos = ab_to_pos(ab);
        gen_btn = btn;
        pending_ticks.push_back(it);
    endtask

    // ------------------------------------------------------------------
    // handshake sides
    // ------------------------------------------------------------------
    function automatic logic take_break();
        if (cycle_num >= CALM_FROM && cycle_num < CALM_TO) return 1'b0;
        return $urandom_range(0, 99) < IDLE_PCT;
    endfunction

    task automatic flag_mismatch(input string msg);
        $display("mismatch at result %0d: %s", result_num, msg);
        mismatch_count++;
    endtask

    // driver: an accepted item is predicted at once, then the next one goes up
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall)
                expected_cmds.push_back(predict_tick(i_in_item));
            if (!i_in_valid || !o_in_stall) begin
                if (pending_ticks.size() != 0 && !take_break()) begin
                    i_in_valid <= 1'b1;
                    i_in_item  <= pending_ticks.pop_front();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: each accepted result against the oldest prediction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                result_num++;
                if (expected_cmds.size() == 0) begin
                    flag_mismatch("result with no item outstanding");
                end else begin
                    head_cmd = expected_cmds.pop_front();
                    if (o_out_item.rotation_valid !== head_cmd.rotation_valid)
                        flag_mismatch($sformatf("rotation_valid %b, want %b",
                            o_out_item.rotation_valid, head_cmd.rotation_valid));
                    if (o_out_item.rotation_delta !== head_cmd.rotation_delta)
                        flag_mismatch($sformatf("rotation_delta %0d, want %0d",
                            o_out_item.rotation_delta, head_cmd.rotation_delta));
                    if (o_out_item.button_valid !== head_cmd.button_valid)
                        flag_mismatch($sformatf("button_valid %b, want %b",
                            o_out_item.button_valid, head_cmd.button_valid));
                    if (o_out_item.button_command !== head_cmd.button_command)
                        flag_mismatch($sformatf("button_command %0d, want %0d",
                            o_out_item.button_command, head_cmd.button_command));
                end
            end
            i_out_stall <= take_break();
        end
    end

    // ------------------------------------------------------------------
    // register writes and phases
    // ------------------------------------------------------------------
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= CFG_DATA_W'(value);
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        apply_reg(idx, CFG_DATA_W'(value));
    endtask

    // sampled on the falling edge so the driver's pops have settled
    task automatic wait_drained();
        @(negedge i_clk);
        while (pending_ticks.size() != 0 || i_in_valid || expected_cmds.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic run_phase(input int step, input int rev, input int rest, input int deb,
                             input int lng, input int dbl, input int lim, input int count);
        write_reg(CFG_VOLUME_STEP, step);
        write_reg(CFG_REVERSE_DIRECTION, rev);
        write_reg(CFG_REST_CODE, rest);
        write_reg(CFG_DEBOUNCE_TICKS, deb);
        write_reg(CFG_LONG_PRESS_TICKS, lng);
        write_reg(CFG_DOUBLE_CLICK_TICKS, dbl);
        write_reg(CFG_DELTA_LIMIT, lim);
        // start each phase from the detent of the new rest code
        gen_rest_pos = ab_to_pos((rest == 0) ? REST_AB_LOW : REST_AB_HIGH);
        rot_home = 1'b1;
        rot_left = 0;
        rot_back = 0;
        @(negedge i_clk);
        repeat (count) pending_ticks.push_back(gen_tick());
        wait_drained();
    endtask

    initial begin
        reset_model();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // one detent forward, pushed at once
        queue_tick(2'b11, 1'b1, 2'd0);
        queue_tick(2'b10, 1'b1, 2'd2);
        queue_tick(2'b00, 1'b1, 2'd2);
        queue_tick(2'b01, 1'b1, 2'd2);
        queue_tick(2'b11, 1'b1, 2'd2);
        // one detent back with the queue full, held until slots free up
        queue_tick(2'b01, 1'b1, 2'd0);
        queue_tick(2'b00, 1'b1, 2'd0);
        queue_tick(2'b10, 1'b1, 2'd0);
        queue_tick(2'b11, 1'b1, 2'd0);
        queue_tick(2'b11, 1'b0, 2'd3);
        // both pins flip at once, twice
        queue_tick(2'b00, 1'b1, 2'd1);
        queue_tick(2'b11, 1'b1, 2'd1);
        // half a turn, left away from rest
        queue_tick(2'b10, 1'b1, 2'd2);
        queue_tick(2'b00, 1'b1, 2'd2);
        wait_drained();

        // moving the rest code mid-turn lets the count run past a detent
        write_reg(CFG_REST_CODE, 0);
        @(negedge i_clk);
        queue_tick(2'b01, 1'b0, 2'd1);
        queue_tick(2'b11, 1'b0, 2'd1);
        queue_tick(2'b10, 1'b1, 2'd1);
        queue_tick(2'b00, 1'b1, 2'd1);
        // full detent onto the low rest code
        queue_tick(2'b01, 1'b1, 2'd3);
        queue_tick(2'b11, 1'b1, 2'd3);
        queue_tick(2'b10, 1'b1, 2'd3);
        queue_tick(2'b00, 1'b1, 2'd1);
        wait_drained();

        // random phases: reset values, then fast timing, extreme and mixed settings
        run_phase(CFG_RESET.volume_step, CFG_RESET.reverse_direction, CFG_RESET.rest_code,
                  CFG_RESET.debounce_ticks, CFG_RESET.long_press_ticks,
                  CFG_RESET.double_click_ticks, CFG_RESET.delta_limit, 120);
        run_phase(1, 0, 0, 1, 6, 4, 127, 200);
        run_phase(100, 1, 3, 2, 12, 8, 1, 200);
        run_phase(37, 0, 2, 3, 25, 1, 50, 150);
        run_phase(100, 1, 1, 255, 65535, 65535, 127, 120);
        run_phase(9, 1, 0, 4, 1, 65535, 20, 150);
        run_phase(5, 0, 3, 2, 40, 20, 64, 100);

        // a stray late result would still show up within the pipeline depth
        repeat (4) @(posedge i_clk);
        if (mismatch_count == 0 && expected_cmds.size() == 0) begin
            $display("rotary_encoder_with_button_top_test: done, clean");
        end else begin
            $display("rotary_encoder_with_button_top_test: done, errors");
        end
        $finish;
    end

    // watchdog against a hung handshake
    initial begin
        #2_000_000;
        $display("rotary_encoder_with_button_top_test: done, errors");
        $finish;
    end

endmodule
